// ===== rtl/core/rmmf_pkg.sv =====
package rmmf_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam int KEY_W    = 16;
	localparam int ENTRY_W  = 2 * KEY_W;
	localparam int DIST_W   = 24;
	localparam int FRAC_W   = 16;
	localparam int RATIO_W  = 17;
	localparam int PROD_W   = RATIO_W + DIST_W;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd42598;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEST   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// chain control: shift moves every cell one step, load takes the head from outside
	typedef struct packed {
		logic shift;
		logic load;
	} chain_ctl_t;

endpackage

// ===== rtl/core/rmmf_cell.sv =====
module rmmf_cell
	import rmmf_pkg::*;
(
	input  logic               clk,
	input  logic               shift_en,
	input  logic [ENTRY_W-1:0] din,
	output logic [ENTRY_W-1:0] dout
);

	logic [ENTRY_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

// ===== rtl/core/rmmf_chain.sv =====
module rmmf_chain
	import rmmf_pkg::*;
(
	input  logic               clk,
	input  chain_ctl_t         ctl,
	input  logic [ENTRY_W-1:0] din,
	output logic [ENTRY_W-1:0] tail
);

	logic [ENTRY_W-1:0] link [MAX_ENTRIES];
	logic [ENTRY_W-1:0] head_in;

	// without load the chain is a ring: the tail wraps back to the head
	assign head_in = ctl.load ? din : link[MAX_ENTRIES-1];

	genvar i;
	generate
		for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
			if (i == 0) begin : g_head
				rmmf_cell u_cell (
					.clk      (clk),
					.shift_en (ctl.shift),
					.din      (head_in),
					.dout     (link[i])
				);
			end else begin : g_body
				rmmf_cell u_cell (
					.clk      (clk),
					.shift_en (ctl.shift),
					.din      (link[i-1]),
					.dout     (link[i])
				);
			end
		end
	endgenerate

	assign tail = link[MAX_ENTRIES-1];

endmodule

// ===== rtl/core/ratio_and_mutual_match_filter.sv =====
// channel  | handshake              | fields
// ---------+------------------------+------------------------------------------------
// item in  | start, busy            | op, query_index, train_index, best_distance,
//          |                        | second_distance, has_second
// result   | match_valid (1 cycle)  | match_query, match_train, match_distance
// config   | ratio_we               | ratio_wdata
//
// Clear and the unused op never raise busy. Append runs through capture, multiply,
// then compare and shift in. A forward test that passes the ratio test adds a full
// turn of the entry ring, since every stored entry passes the single tail comparator
// once; a result strobe, raised only on a hit, follows the turn.
// Reset empties the table by clearing the entry count; entries hold no reset.
// The result cannot be stalled; a new item may be accepted in the strobe cycle.
module ratio_and_mutual_match_filter
	import rmmf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [KEY_W-1:0]   query_index,
	input  logic [KEY_W-1:0]   train_index,
	input  logic [DIST_W-1:0]  best_distance,
	input  logic [DIST_W-1:0]  second_distance,
	input  logic               has_second,
	input  logic               ratio_we,
	input  logic [RATIO_W-1:0] ratio_wdata,
	output logic               match_valid,
	output logic [KEY_W-1:0]   match_query,
	output logic [KEY_W-1:0]   match_train,
	output logic [DIST_W-1:0]  match_distance
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_EVAL = 4'b0100,
		S_SCAN = 4'b1000
	} state_t;

	state_t             state_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   scan_q;
	logic               hit_q;
	logic               strobe_q;

	op_t                op_q;
	logic [KEY_W-1:0]   query_q;
	logic [KEY_W-1:0]   train_q;
	logic [DIST_W-1:0]  best_q;
	logic [DIST_W-1:0]  second_q;
	logic               has_q;
	logic [PROD_W-1:0]  prod_q;

	logic               accept;
	logic [PROD_W-1:0]  lhs;
	logic               ratio_ok;
	logic               room;
	logic [CNT_W:0]     pos_sum;
	logic               tail_valid;
	logic               tail_hit;
	logic               scan_last;
	chain_ctl_t         ctl;
	logic [ENTRY_W-1:0] tail;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign lhs      = PROD_W'({best_q, {FRAC_W{1'b0}}});
	assign ratio_ok = has_q && (lhs <= prod_q);
	assign room     = (count_q < CNT_W'(MAX_ENTRIES));

	// at scan step k the tail holds the entry that sat at place MAX_ENTRIES-1-k;
	// it is a stored entry when that place is below the count
	assign pos_sum    = (CNT_W+1)'(scan_q) + (CNT_W+1)'(count_q);
	assign tail_valid = (pos_sum >= (CNT_W+1)'(MAX_ENTRIES));
	assign tail_hit   = tail_valid && (tail == {train_q, query_q});
	assign scan_last  = (scan_q == IDX_W'(MAX_ENTRIES - 1));

	always_comb begin
		ctl = '0;
		unique case (state_q) inside
			S_EVAL: begin
				if (op_q == OP_APPEND && ratio_ok && room) begin
					ctl.shift = 1'b1;
					ctl.load  = 1'b1;
				end
			end
			S_SCAN: begin
				ctl.shift = 1'b1;
			end
			S_IDLE, S_MUL: begin
				ctl = '0;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	rmmf_chain u_chain (
		.clk  (clk),
		.ctl  (ctl),
		.din  ({query_q, train_q}),
		.tail (tail)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(op);
			query_q  <= query_index;
			train_q  <= train_index;
			best_q   <= best_distance;
			second_q <= second_distance;
			has_q    <= has_second;
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(ratio_q) * PROD_W'(second_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (ratio_we) begin
			ratio_q <= ratio_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			scan_q   <= '0;
			hit_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op_t'(op)) inside
							OP_CLEAR: count_q <= '0;
							OP_APPEND, OP_TEST: state_q <= S_MUL;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_MUL: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_IDLE;
					if (op_q == OP_APPEND && ratio_ok && room) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (op_q == OP_TEST && ratio_ok) begin
						state_q <= S_SCAN;
						scan_q  <= '0;
						hit_q   <= 1'b0;
					end
				end
				S_SCAN: begin
					hit_q  <= hit_q || tail_hit;
					scan_q <= scan_q + IDX_W'(1);
					if (scan_last) begin
						state_q  <= S_IDLE;
						strobe_q <= hit_q || tail_hit;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign match_valid    = strobe_q;
	assign match_query    = query_q;
	assign match_train    = train_q;
	assign match_distance = best_q;

endmodule

// ===== rtl/core/rmmf_checker.sv =====
module rmmf_checker
	import rmmf_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         op,
	input logic               match_valid,
	input logic [KEY_W-1:0]   match_query,
	input logic [KEY_W-1:0]   match_train,
	input logic [DIST_W-1:0]  match_distance
);

	// a result only closes a forward test that kept the block busy
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		match_valid |-> $past(busy))
		else $error("result without a preceding busy phase");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		match_valid |=> !match_valid)
		else $error("result strobe longer than one cycle");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		match_valid |-> !busy)
		else $error("result shown while still busy");

	a_short_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_CLEAR || op == OP_NONE)) |=> !busy)
		else $error("clear or unused op raised busy");

	a_long_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_APPEND || op == OP_TEST)) |=> busy)
		else $error("append or test item not taken up");

endmodule

bind ratio_and_mutual_match_filter rmmf_checker u_rmmf_checker (.*);

// ===== tb/match_filter_checker.sv =====
`timescale 1ns / 100ps

module match_filter_checker
	import rmmf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         op,
	input  logic [KEY_W-1:0]   query_index,
	input  logic [KEY_W-1:0]   train_index,
	input  logic [DIST_W-1:0]  best_distance,
	input  logic [DIST_W-1:0]  second_distance,
	input  logic               has_second,
	input  logic               ratio_we,
	input  logic [RATIO_W-1:0] ratio_wdata,
	input  logic               match_valid,
	input  logic [KEY_W-1:0]   match_query,
	input  logic [KEY_W-1:0]   match_train,
	input  logic [DIST_W-1:0]  match_distance,
	output int                 pending,
	output int                 errors
);

	typedef struct packed {
		logic [KEY_W-1:0]  query;
		logic [KEY_W-1:0]  train;
		logic [DIST_W-1:0] distance;
	} match_rec_t;

	logic [RATIO_W-1:0] ratio;
	logic [ENTRY_W-1:0] backward_keys [MAX_ENTRIES];
	logic [CNT_W-1:0]   entry_count;
	match_rec_t         expected_matches [$];

	task automatic report(string msg);
		errors++;
		if (errors <= 40)
			$display("%0t ns: %s", $time, msg);
	endtask

	// best/second <= ratio, cross-multiplied
	function automatic bit ratio_ok(logic [DIST_W-1:0] best, logic [DIST_W-1:0] second,
			logic second_present);
		logic [PROD_W-1:0] lhs;
		logic [PROD_W-1:0] rhs;
		lhs = PROD_W'(best) << FRAC_W;
		rhs = PROD_W'(ratio) * PROD_W'(second);
		return second_present && (lhs <= rhs);
	endfunction

	task automatic predict_item();
		logic [ENTRY_W-1:0] wanted;
		match_rec_t         rec;
		bit                 passed;
		bit                 hit;
		passed = ratio_ok(best_distance, second_distance, has_second);
		hit = 1'b0;
		case (op_t'(op))
			OP_CLEAR: entry_count = '0;
			OP_APPEND: begin
				if (passed && entry_count < MAX_ENTRIES) begin
					backward_keys[entry_count[IDX_W-1:0]] = {query_index, train_index};
					entry_count++;
				end
			end
			OP_TEST: begin
				if (passed) begin
					wanted = {train_index, query_index};
					for (int i = 0; i < entry_count; i++)
						if (backward_keys[i] == wanted)
							hit = 1'b1;
					if (hit) begin
						rec = {query_index, train_index, best_distance};
						expected_matches.insert(expected_matches.size(), rec);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_match();
		match_rec_t want;
		if (expected_matches.size() == 0) begin
			report($sformatf("unexpected match q=%h t=%h d=%h",
				match_query, match_train, match_distance));
		end else begin
			want = expected_matches.pop_front();
			if (match_query !== want.query)
				report($sformatf("match_query %h, expected %h", match_query, want.query));
			if (match_train !== want.train)
				report($sformatf("match_train %h, expected %h", match_train, want.train));
			if (match_distance !== want.distance)
				report($sformatf("match_distance %h, expected %h",
					match_distance, want.distance));
		end
	endtask

	// results first: a new item may be taken in the strobe cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio = RATIO_RESET;
			entry_count = '0;
			expected_matches.delete();
			errors = 0;
		end else begin
			if (match_valid)
				check_match();
			if (ratio_we)
				ratio = ratio_wdata;
			if (start && !busy)
				predict_item();
		end
		pending = expected_matches.size();
	end

endmodule

// ===== tb/ratio_and_mutual_match_filter_test.sv =====
`timescale 1ns / 100ps

module ratio_and_mutual_match_filter_test;
	import rmmf_pkg::*;

	localparam int STALL_LIMIT = 8 * MAX_ENTRIES;
	localparam int PHASE_ITEMS = 145;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         op = OP_NONE;
	logic [KEY_W-1:0]   query_index = '0;
	logic [KEY_W-1:0]   train_index = '0;
	logic [DIST_W-1:0]  best_distance = '0;
	logic [DIST_W-1:0]  second_distance = '0;
	logic               has_second = 1'b0;
	logic               ratio_we = 1'b0;
	logic [RATIO_W-1:0] ratio_wdata = '0;
	logic               match_valid;
	logic [KEY_W-1:0]   match_query;
	logic [KEY_W-1:0]   match_train;
	logic [DIST_W-1:0]  match_distance;
	int                 pending;
	int                 errors;

	int                 idle_pct = 0;
	int                 phase_items = 0;
	int                 quiet_cycles = 0;
	logic [RATIO_W-1:0] ratio_now = RATIO_RESET;
	logic [ENTRY_W-1:0] loaded_pairs [$];

	always #5 clk = ~clk;

	ratio_and_mutual_match_filter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.query_index     (query_index),
		.train_index     (train_index),
		.best_distance   (best_distance),
		.second_distance (second_distance),
		.has_second      (has_second),
		.ratio_we        (ratio_we),
		.ratio_wdata     (ratio_wdata),
		.match_valid     (match_valid),
		.match_query     (match_query),
		.match_train     (match_train),
		.match_distance  (match_distance)
	);

	match_filter_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.query_index     (query_index),
		.train_index     (train_index),
		.best_distance   (best_distance),
		.second_distance (second_distance),
		.has_second      (has_second),
		.ratio_we        (ratio_we),
		.ratio_wdata     (ratio_wdata),
		.match_valid     (match_valid),
		.match_query     (match_query),
		.match_train     (match_train),
		.match_distance  (match_distance),
		.pending         (pending),
		.errors          (errors)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || match_valid || ratio_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(op_t kind, logic [KEY_W-1:0] q, logic [KEY_W-1:0] t,
			logic [DIST_W-1:0] b, logic [DIST_W-1:0] s, logic h);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= kind;
		query_index <= q;
		train_index <= t;
		best_distance <= b;
		second_distance <= s;
		has_second <= h;
		do
			@(posedge clk);
		while (busy);
		if (kind != OP_NONE)
			phase_items++;
	endtask

	// wait out results and any scan that ends without one
	task automatic settle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0 || busy);
		repeat (MAX_ENTRIES + 16) @(posedge clk);
	endtask

	task automatic write_ratio(logic [RATIO_W-1:0] value);
		settle();
		ratio_we <= 1'b1;
		ratio_wdata <= value;
		ratio_now = value;
		@(posedge clk);
		ratio_we <= 1'b0;
	endtask

	// largest best distance that still passes for this second distance
	function automatic logic [DIST_W-1:0] pass_limit(logic [RATIO_W-1:0] r,
			logic [DIST_W-1:0] s);
		logic [PROD_W-1:0] prod;
		prod = (PROD_W'(r) * PROD_W'(s)) >> FRAC_W;
		return (prod > PROD_W'(24'hFFFFFF)) ? 24'hFFFFFF : prod[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] rand_dist();
		case ($urandom_range(4))
			0: return '0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(1, 300));
			3: return 24'(1) << $urandom_range(23);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		if ($urandom_range(4) == 0)
			return 16'($urandom_range(7));
		return 16'($urandom);
	endfunction

	task automatic pick_dists(bit want_pass, output logic [DIST_W-1:0] b,
			output logic [DIST_W-1:0] s, output logic h);
		logic [DIST_W-1:0] lim;
		s = rand_dist();
		h = 1'b1;
		lim = pass_limit(ratio_now, s);
		if (want_pass) begin
			b = ($urandom_range(2) == 0) ? lim : 24'($urandom % (32'(lim) + 1));
		end else if (lim != 24'hFFFFFF && $urandom_range(3) != 0) begin
			if ($urandom_range(1) == 0)
				b = lim + 1'b1;
			else
				b = 24'(32'(lim) + 1 + ($urandom % (32'hFFFFFF - 32'(lim))));
		end else begin
			h = 1'b0;
			b = rand_dist();
		end
	endtask

	task automatic directed_items();
		logic [DIST_W-1:0] lim;
		lim = pass_limit(ratio_now, 24'd100000);
		send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
		// both distances zero passes
		send_item(OP_APPEND, 16'hFFFF, 16'h0000, 24'd0, 24'd0, 1'b1);
		send_item(OP_TEST, 16'h0000, 16'hFFFF, 24'd0, 24'd0, 1'b1);
		send_item(OP_TEST, 16'hFFFF, 16'h0000, 24'd0, 24'd0, 1'b1);
		send_item(OP_TEST, 16'h0000, 16'hFFFF, 24'd0, 24'd5, 1'b0);
		send_item(OP_APPEND, 16'd1, 16'd2, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
		send_item(OP_TEST, 16'd2, 16'd1, 24'd0, 24'd5, 1'b1);
		// zero second distance rejects a nonzero best
		send_item(OP_APPEND, 16'd3, 16'd4, 24'd1, 24'd0, 1'b1);
		send_item(OP_TEST, 16'd4, 16'd3, 24'd0, 24'd5, 1'b1);
		send_item(OP_APPEND, 16'd5, 16'd6, 24'd0, 24'd5, 1'b0);
		send_item(OP_TEST, 16'd6, 16'd5, 24'd0, 24'd5, 1'b1);
		send_item(OP_APPEND, 16'd7, 16'd8, lim, 24'd100000, 1'b1);
		send_item(OP_TEST, 16'd8, 16'd7, lim, 24'd100000, 1'b1);
		send_item(OP_TEST, 16'd8, 16'd7, lim + 1'b1, 24'd100000, 1'b1);
		// duplicate entries give a single match
		send_item(OP_APPEND, 16'd9, 16'd10, 24'd2, 24'd1000, 1'b1);
		send_item(OP_APPEND, 16'd9, 16'd10, 24'd2, 24'd1000, 1'b1);
		send_item(OP_TEST, 16'd10, 16'd9, 24'd3, 24'd1000, 1'b1);
		send_item(OP_NONE, 16'h0000, 16'hFFFF, 24'd0, 24'd0, 1'b1);
		send_item(OP_TEST, 16'h0000, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
		send_item(OP_CLEAR, 16'd0, 16'd0, 24'd0, 24'd0, 1'b0);
		send_item(OP_TEST, 16'h0000, 16'hFFFF, 24'd0, 24'd0, 1'b1);
	endtask

	task automatic append_random(bit want_pass);
		logic [KEY_W-1:0]  q;
		logic [KEY_W-1:0]  t;
		logic [DIST_W-1:0] b;
		logic [DIST_W-1:0] s;
		logic              h;
		q = rand_key();
		t = rand_key();
		pick_dists(want_pass, b, s, h);
		send_item(OP_APPEND, q, t, b, s, h);
		loaded_pairs.insert(loaded_pairs.size(), {q, t});
	endtask

	// mostly clear/append/test runs built on stored pairs, some noise
	task automatic random_burst();
		logic [ENTRY_W-1:0] pair;
		logic [KEY_W-1:0]   q;
		logic [KEY_W-1:0]   t;
		logic [DIST_W-1:0]  b;
		logic [DIST_W-1:0]  s;
		logic               h;
		int                 n;
		int                 sel;
		if ($urandom_range(3) == 0) begin
			send_item(OP_CLEAR, rand_key(), rand_key(), rand_dist(), rand_dist(), 1'($urandom));
			loaded_pairs.delete();
		end
		n = $urandom_range(10);
		repeat (n) append_random($urandom_range(99) < 85);
		n = $urandom_range(1, 5);
		repeat (n) begin
			sel = $urandom_range(99);
			if (sel < 8) begin
				send_item(OP_NONE, rand_key(), rand_key(), rand_dist(), rand_dist(), 1'($urandom));
			end else if (sel < 80 && loaded_pairs.size() != 0) begin
				if (loaded_pairs.size() > 12 && $urandom_range(2) == 0)
					pair = loaded_pairs[$urandom_range(loaded_pairs.size() - 12,
						loaded_pairs.size() - 1)];
				else
					pair = loaded_pairs[$urandom_range(loaded_pairs.size() - 1)];
				pick_dists($urandom_range(99) < 85, b, s, h);
				if (sel < 70)
					send_item(OP_TEST, pair[KEY_W-1:0], pair[ENTRY_W-1:KEY_W], b, s, h);
				else
					send_item(OP_TEST, pair[ENTRY_W-1:KEY_W], pair[KEY_W-1:0], b, s, h);
			end else begin
				q = rand_key();
				t = rand_key();
				pick_dists($urandom_range(1), b, s, h);
				send_item(op_t'(sel % 3), q, t, b, s, h);
			end
		end
	endtask

	initial begin
		int                 phase_idle [4];
		logic [RATIO_W-1:0] phase_ratio [4];
		phase_idle = '{0, 85, 0, 24};
		phase_ratio = '{17'd65536, 17'd0, 17'd131071, 17'($urandom_range(1, 65535))};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		for (int p = 0; p < 4; p++) begin
			write_ratio(phase_ratio[p]);
			idle_pct = phase_idle[p];
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				random_burst();
		end
		settle();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
